@@ design/ptt_pkg.sv @@
// ptt_pkg: shared types and constants for the periodic timer table.
// Operation and status codes, cell control and report structs.
// No dependencies.
package ptt_pkg;

   localparam int NUM_SLOTS_DEF  = 16;
   localparam int TIME_WIDTH_DEF = 32;
   localparam int MAX_RESULTS    = 16;
   localparam int OP_W           = 2;
   localparam int SLOT_W         = 6;
   localparam int PERIOD_W       = 32;
   localparam int DELAY_W        = 32;
   localparam int STATUS_W       = 2;
   localparam int RPT_CNT_W      = $clog2(MAX_RESULTS + 1);

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 2'd0,
      OP_REGISTER   = 2'd1,
      OP_SET_PERIOD = 2'd2,
      OP_CANCEL     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_EXPIRED = 2'd1,
      ST_FULL    = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                shift;     // advance the scan token
      logic                act;       // token holder acts this cycle
      op_type              op;
      logic                claimed;   // a free slot was already taken
      logic                set_en;
      logic                cancel_en;
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] period;
      logic [DELAY_W-1:0]  delay;
   } cell_ctl_type;

   // From a cell back to the controller; only the token holder drives nonzero.
   typedef struct packed {
      logic                expire;
      logic                take;
      logic [PERIOD_W-1:0] period;
   } cell_rpt_type;

endpackage

@@ design/ptt_cell.sv @@
// ptt_cell: one timer slot (active mark, period, down-counter) with one
// stage of the scan token chain.
// Depends on ptt_pkg.
module ptt_cell #(
   parameter int TIME_WIDTH = ptt_pkg::TIME_WIDTH_DEF,
   parameter int SLOT_ID    = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ptt_pkg::cell_ctl_type ctl,
   input  logic                  token_in,
   output logic                  token_out,
   output ptt_pkg::cell_rpt_type rpt
);
   import ptt_pkg::*;

   logic                  active_ff;
   logic                  active_in;
   logic                  token_ff;
   logic                  token_in_nxt;
   logic [PERIOD_W-1:0]   period_ff;
   logic [PERIOD_W-1:0]   period_in;
   logic [TIME_WIDTH-1:0] counter_ff;
   logic [TIME_WIDTH-1:0] counter_in;

   logic                           hit;
   logic                           sel;
   logic                           tick_hit;
   logic                           expire;
   logic                           take;
   logic [TIME_WIDTH+PERIOD_W-1:0] reload_ext;
   logic [TIME_WIDTH+DELAY_W-1:0]  delay_ext;

   assign hit        = token_ff && ctl.act;
   assign sel        = (ctl.slot == SLOT_W'(SLOT_ID));
   assign tick_hit   = hit && (ctl.op == OP_TICK) && active_ff;
   // counter reaches zero after this decrement
   assign expire     = tick_hit && (counter_ff == TIME_WIDTH'(1));
   assign take       = hit && (ctl.op == OP_REGISTER) && !active_ff && !ctl.claimed;
   assign reload_ext = {{TIME_WIDTH{1'b0}}, period_ff};
   assign delay_ext  = {{TIME_WIDTH{1'b0}}, ctl.delay};

   always_comb begin
      token_in_nxt = ctl.shift ? token_in : token_ff;
      active_in    = active_ff;
      period_in    = period_ff;
      counter_in   = counter_ff;
      if (take) begin
         active_in  = 1'b1;
         period_in  = ctl.period;
         counter_in = delay_ext[TIME_WIDTH-1:0];
      end
      if (tick_hit) begin
         if (expire) begin
            if (period_ff == '0) begin
               active_in = 1'b0;
            end else begin
               counter_in = reload_ext[TIME_WIDTH-1:0];
            end
         end else begin
            counter_in = counter_ff - TIME_WIDTH'(1);
         end
      end
      if (ctl.set_en && sel) begin
         period_in = ctl.period;
      end
      if (ctl.cancel_en && sel) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         token_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         token_ff  <= token_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      period_ff  <= period_in;
      counter_ff <= counter_in;
   end

   assign token_out  = token_ff;
   assign rpt.expire = expire;
   assign rpt.take   = take;
   assign rpt.period = expire ? period_ff : '0;

endmodule

@@ design/periodic_timer_table_unit.sv @@
// periodic_timer_table_unit: top level of the timer slot table.
// Instantiates a chain of ptt_cell and the scan controller; depends on ptt_pkg.
//
//   channel | ports                                     | direction
//   --------+-------------------------------------------+----------
//   request | req_valid req_stall req_operation req_slot | in
//           | req_period req_delay                      |
//   response| rsp_valid rsp_stall rsp_status            | out
//           | rsp_slot_number rsp_expired_period rsp_last|
//
// Tick and register walk a token down the cell chain, one cell per cycle while
// the response output is free. Set period and cancel go through S_APPLY, then S_EMIT.
// A stalled response pauses the scan; each expiry needs the output register.
// Synchronous active-high reset clears all slots.
module periodic_timer_table_unit #(
   parameter int NUM_SLOTS  = ptt_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = ptt_pkg::TIME_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ptt_pkg::op_type                 req_operation,
   input  logic [ptt_pkg::SLOT_W-1:0]      req_slot,
   input  logic [ptt_pkg::PERIOD_W-1:0]    req_period,
   input  logic [ptt_pkg::DELAY_W-1:0]     req_delay,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ptt_pkg::status_type             rsp_status,
   output logic [ptt_pkg::SLOT_W-1:0]      rsp_slot_number,
   output logic [ptt_pkg::PERIOD_W-1:0]    rsp_expired_period,
   output logic                            rsp_last
);
   import ptt_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_APPLY = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [DELAY_W-1:0]    delay_ff, delay_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  claimed_ff, claimed_in;
   logic [RPT_CNT_W-1:0]  rpt_cnt_ff, rpt_cnt_in;
   status_type            pend_status_ff, pend_status_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [PERIOD_W-1:0]   pend_period_ff, pend_period_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [PERIOD_W-1:0]   rsp_period_ff, rsp_period_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  start;
   logic                  out_free;
   logic                  act;
   logic                  slot_ok;
   logic                  push;
   cell_ctl_type          ctl;
   cell_rpt_type          rpt_all;
   logic [NUM_SLOTS-1:0]  token;
   cell_rpt_type          rpt [NUM_SLOTS];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign start     = accept && (req_operation == OP_TICK || req_operation == OP_REGISTER);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign act       = (state_ff == S_SCAN) && out_free;
   assign slot_ok   = ({1'b0, slot_ff} < (SLOT_W + 1)'(NUM_SLOTS));

   assign ctl.shift     = start || act;
   assign ctl.act       = act;
   assign ctl.op        = op_ff;
   assign ctl.claimed   = claimed_ff;
   assign ctl.set_en    = (state_ff == S_APPLY) && (op_ff == OP_SET_PERIOD) && slot_ok;
   assign ctl.cancel_en = (state_ff == S_APPLY) && (op_ff == OP_CANCEL) && slot_ok;
   assign ctl.slot      = slot_ff;
   assign ctl.period    = period_ff;
   assign ctl.delay     = delay_ff;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      ptt_cell #(
         .TIME_WIDTH (TIME_WIDTH),
         .SLOT_ID    (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .token_in  ((i == 0) ? start : token[(i == 0) ? 0 : i - 1]),
         .token_out (token[i]),
         .rpt       (rpt[i])
      );
   end

   // Only the token holder reports, so an OR collects its report.
   always_comb begin
      rpt_all = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         rpt_all = rpt_all | rpt[i];
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      slot_in        = slot_ff;
      period_in      = period_ff;
      delay_in       = delay_ff;
      idx_in         = idx_ff;
      claimed_in     = claimed_ff;
      rpt_cnt_in     = rpt_cnt_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_period_in = pend_period_ff;
      push           = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_period_in  = rsp_period_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in          = req_operation;
               slot_in        = req_slot;
               period_in      = req_period;
               delay_in       = req_delay;
               idx_in         = '0;
               claimed_in     = 1'b0;
               rpt_cnt_in     = '0;
               pend_status_in = (req_operation == OP_REGISTER) ? ST_FULL : ST_DONE;
               pend_slot_in   = '0;
               pend_period_in = '0;
               state_in       = start ? S_SCAN : S_APPLY;
            end
         end
         S_SCAN: begin
            if (act) begin
               if (rpt_all.expire && (rpt_cnt_ff < RPT_CNT_W'(MAX_RESULTS))) begin
                  // flush the previous expiry, it is not the final one
                  if (pend_status_ff == ST_EXPIRED) begin
                     push          = 1'b1;
                     rsp_status_in = pend_status_ff;
                     rsp_slot_in   = pend_slot_ff;
                     rsp_period_in = pend_period_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_status_in = ST_EXPIRED;
                  pend_slot_in   = SLOT_W'(idx_ff);
                  pend_period_in = rpt_all.period;
                  rpt_cnt_in     = rpt_cnt_ff + RPT_CNT_W'(1);
               end
               if (rpt_all.take) begin
                  claimed_in     = 1'b1;
                  pend_status_in = ST_DONE;
                  pend_slot_in   = SLOT_W'(idx_ff);
               end
               idx_in = idx_ff + IDX_W'(1);
               if (token[NUM_SLOTS-1]) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_APPLY: begin
            pend_status_in = slot_ok ? ST_DONE : ST_INVALID;
            pend_slot_in   = slot_ff;
            pend_period_in = '0;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               push          = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_period_in = pend_period_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      slot_ff        <= slot_in;
      period_ff      <= period_in;
      delay_ff       <= delay_in;
      idx_ff         <= idx_in;
      claimed_ff     <= claimed_in;
      rpt_cnt_ff     <= rpt_cnt_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      pend_period_ff <= pend_period_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_period_ff  <= rsp_period_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_number    = rsp_slot_ff;
   assign rsp_expired_period = rsp_period_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

@@ design/ptt_checker.sv @@
// ptt_checker: port-level assertions for periodic_timer_table_unit,
// attached by the bind statement at the end. Depends on ptt_pkg.
module ptt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input ptt_pkg::status_type          rsp_status,
   input logic [ptt_pkg::SLOT_W-1:0]   rsp_slot_number,
   input logic [ptt_pkg::PERIOD_W-1:0] rsp_expired_period,
   input logic                         rsp_last
);
   import ptt_pkg::*;

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot_number) && $stable(rsp_expired_period) && $stable(rsp_last))
      else $error("stalled response changed");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_EXPIRED |-> rsp_last)
      else $error("non-expiry response without last");

   a_period_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_EXPIRED |-> rsp_expired_period == '0)
      else $error("period reported outside an expiry");

   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_slot_number == '0)
      else $error("table full with nonzero slot");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_slot_number    (rsp_slot_number),
   .rsp_expired_period (rsp_expired_period),
   .rsp_last           (rsp_last)
);

@@ test/periodic_timer_table_unit_test.sv @@
// Self-checking testbench for periodic_timer_table_unit: directed and random
// tick/register/set-period/cancel traffic, checked against a slot-table predictor.
// Depends on ptt_pkg and the periodic_timer_table_unit RTL.
`timescale 1ns / 1ps

module periodic_timer_table_unit_test;
   import ptt_pkg::*;

   localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
   localparam int TIME_WIDTH  = TIME_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] period;
      logic                last;
   } timer_result_type;

   class timer_scoreboard_type;
      bit                    active[NUM_SLOTS];
      logic [PERIOD_W-1:0]   period_of[NUM_SLOTS];
      logic [TIME_WIDTH-1:0] count_of[NUM_SLOTS];
      timer_result_type      expected_q[$];
      int                    errors;
      int                    checked;
      int                    status_seen[4];

      function new();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            active[i]    = 1'b0;
            period_of[i] = '0;
            count_of[i]  = '0;
         end
         errors  = 0;
         checked = 0;
         for (int i = 0; i < 4; i++) status_seen[i] = 0;
      endfunction

      function void push_result(status_type st, logic [SLOT_W-1:0] slot,
                                logic [PERIOD_W-1:0] per, logic last);
         timer_result_type r;
         r = '{st, slot, per, last};
         expected_q.push_back(r);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Work out the results of one accepted transaction and update the table.
      function void note_request(op_type op, logic [SLOT_W-1:0] slot,
                                 logic [PERIOD_W-1:0] per, logic [DELAY_W-1:0] dly);
         int               n;
         int               found;
         timer_result_type r;
         n     = 0;
         found = -1;
         case (op)
            OP_TICK: begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (active[i]) begin
                     count_of[i] = count_of[i] - 1'b1;
                     if (count_of[i] == '0) begin
                        if (n < MAX_RESULTS) begin
                           push_result(ST_EXPIRED, SLOT_W'(i), period_of[i], 1'b0);
                           n++;
                        end
                        if (period_of[i] == '0)
                           active[i] = 1'b0;
                        else
                           count_of[i] = TIME_WIDTH'(period_of[i]);
                     end
                  end
               end
               if (n == 0) begin
                  push_result(ST_DONE, '0, '0, 1'b1);
               end else begin
                  r = expected_q.pop_back();
                  r.last = 1'b1;
                  expected_q.push_back(r);
               end
            end
            OP_REGISTER: begin
               for (int i = NUM_SLOTS - 1; i >= 0; i--)
                  if (!active[i]) found = i;
               if (found < 0) begin
                  push_result(ST_FULL, '0, '0, 1'b1);
               end else begin
                  active[found]    = 1'b1;
                  period_of[found] = per;
                  count_of[found]  = TIME_WIDTH'(dly);
                  push_result(ST_DONE, SLOT_W'(found), '0, 1'b1);
               end
            end
            default: begin
               if (slot >= NUM_SLOTS) begin
                  push_result(ST_INVALID, slot, '0, 1'b1);
               end else begin
                  if (op == OP_SET_PERIOD)
                     period_of[slot] = per;
                  else
                     active[slot] = 1'b0;
                  push_result(ST_DONE, slot, '0, 1'b1);
               end
            end
         endcase
      endfunction

      function void check_response(status_type st, logic [SLOT_W-1:0] slot,
                                   logic [PERIOD_W-1:0] per, logic last);
         timer_result_type e;
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected response status=%0d slot=%0d period=%h last=%b",
                        $realtime, st, slot, per, last);
            return;
         end
         e = expected_q.pop_front();
         status_seen[e.status]++;
         if (st !== e.status || slot !== e.slot || per !== e.period || last !== e.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display({"%0t: mismatch exp status=%0d slot=%0d period=%h last=%b, ",
                         "got status=%0d slot=%0d period=%h last=%b"},
                        $realtime, e.status, e.slot, e.period, e.last, st, slot, per, last);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   op_type              req_operation;
   logic [SLOT_W-1:0]   req_slot;
   logic [PERIOD_W-1:0] req_period;
   logic [DELAY_W-1:0]  req_delay;
   logic                rsp_valid;
   logic                rsp_stall;
   status_type          rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_number;
   logic [PERIOD_W-1:0] rsp_expired_period;
   logic                rsp_last;

   timer_scoreboard_type sb = new();
   int cycles = 0;
   int op_count[4] = '{0, 0, 0, 0};
   int req_calm = 0;

   periodic_timer_table_unit #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_WIDTH(TIME_WIDTH)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_slot          (req_slot),
      .req_period        (req_period),
      .req_delay         (req_delay),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_number   (rsp_slot_number),
      .rsp_expired_period(rsp_expired_period),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL periodic_timer_table_unit");
         $finish;
      end
   end

   // Present one transaction after a random gap and hold it until accepted.
   task automatic send_request(input op_type op, input logic [SLOT_W-1:0] slot,
                               input logic [PERIOD_W-1:0] per,
                               input logic [DELAY_W-1:0] dly);
      int gap;
      if (req_calm > 0) begin
         gap = 0;
         req_calm--;
      end else begin
         gap = $urandom_range(0, 11);
         if ($urandom_range(0, 7) == 0) req_calm = $urandom_range(5, 20);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_slot      <= slot;
      req_period    <= per;
      req_delay     <= dly;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(op, slot, per, dly);
      op_count[op]++;
   endtask

   // Mostly short periods so slots keep expiring, with one-shots and extremes.
   function automatic logic [PERIOD_W-1:0] pick_period();
      int k;
      k = $urandom_range(0, 9);
      if (k < 3) return '0;
      if (k < 8) return $urandom_range(1, 6);
      if (k == 8) return '1;
      return $urandom;
   endfunction

   // Response side: random stall stretches, with calm runs of no stall.
   initial begin
      int hold;
      int calm;
      calm = 0;
      forever begin
         if (calm > 0) begin
            hold = 0;
            calm--;
         end else begin
            hold = $urandom_range(0, 11);
            if ($urandom_range(0, 7) == 0) calm = $urandom_range(8, 40);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_response(rsp_status, rsp_slot_number, rsp_expired_period, rsp_last);
      end
   end

   initial begin
      int                  k;
      op_type              op;
      logic [DELAY_W-1:0]  dly;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_TICK;
      req_slot      <= '0;
      req_period    <= '0;
      req_delay     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, invalid and inactive slots, one-shot,
      // maximum period, zero delay, full table, a tick expiring every slot.
      send_request(OP_TICK, '0, '0, '0);
      send_request(OP_CANCEL, 6'd63, '0, '0);
      send_request(OP_SET_PERIOD, SLOT_W'(NUM_SLOTS), 32'h1234_5678, '0);
      send_request(OP_SET_PERIOD, 6'd7, 32'd9, '0);
      send_request(OP_CANCEL, 6'd5, '0, '0);
      send_request(OP_REGISTER, '0, '0, 32'd1);
      send_request(OP_REGISTER, '0, '1, 32'd1);
      send_request(OP_REGISTER, '0, 32'd2, '0);
      send_request(OP_TICK, '1, '1, '1);
      send_request(OP_SET_PERIOD, 6'd2, 32'd1, '0);
      send_request(OP_CANCEL, 6'd1, '0, '0);
      send_request(OP_CANCEL, 6'd2, '0, '0);
      for (int i = 0; i < NUM_SLOTS; i++)
         send_request(OP_REGISTER, '0, PERIOD_W'(i % 4 + 1), 32'd1);
      send_request(OP_REGISTER, '0, 32'd3, 32'd3);
      send_request(OP_TICK, '0, '0, '0);

      // Random: tick-heavy mix so slots cycle through expiry, reload and reuse.
      for (int n = 0; n < 130; n++) begin
         k = $urandom_range(0, 19);
         if (k < 8) op = OP_TICK;
         else if (k < 13) op = OP_REGISTER;
         else if (k < 16) op = OP_SET_PERIOD;
         else op = OP_CANCEL;
         k = $urandom_range(0, 9);
         if (k < 8) dly = $urandom_range(1, 8);
         else if (k == 8) dly = '0;
         else dly = $urandom;
         if ($urandom_range(0, 6) == 0)
            send_request(op, SLOT_W'($urandom_range(NUM_SLOTS, 63)), pick_period(), dly);
         else
            send_request(op, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), pick_period(), dly);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * NUM_SLOTS + 8) @(posedge clock);

      $display("Sent %0d ticks, %0d registers, %0d set-periods, %0d cancels.",
               op_count[OP_TICK], op_count[OP_REGISTER], op_count[OP_SET_PERIOD],
               op_count[OP_CANCEL]);
      $display({"Checked %0d responses: %0d done, %0d expired, %0d full, ",
                "%0d invalid; %0d errors."},
               sb.checked, sb.status_seen[ST_DONE], sb.status_seen[ST_EXPIRED],
               sb.status_seen[ST_FULL], sb.status_seen[ST_INVALID], sb.errors);
      if (sb.errors == 0)
         $display("PASS periodic_timer_table_unit");
      else
         $display("FAIL periodic_timer_table_unit");
      $finish;
   end

endmodule

@@ files.f @@
design/ptt_pkg.sv
design/ptt_cell.sv
design/periodic_timer_table_unit.sv
design/ptt_checker.sv
test/periodic_timer_table_unit_test.sv
